// ----- rtl/csp_pkg.sv -----
package csp_pkg;

  localparam int unsigned NUM_LABELS  = 11;
  localparam int unsigned LABEL_CHARS = 15;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic REC_CHAR = 1'b0;
  localparam logic REC_END  = 1'b1;

  localparam logic [1:0] TT_TEXT      = 2'd0;
  localparam logic [1:0] TT_COMMENT   = 2'd1;
  localparam logic [1:0] TT_DIRECTIVE = 2'd2;
  localparam logic [1:0] TT_DROPPED   = 2'd3;

  localparam logic [3:0] ID_UNKNOWN = 4'd0;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic       rec_kind;
    logic [1:0] token_type;
    logic [3:0] directive_id;
    logic [7:0] char_out;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } res_pair_t;

  typedef logic [LABEL_CHARS*8-1:0] label_text_t;

  localparam label_text_t LONG_TEXT [NUM_LABELS] = '{
    "new\137song", "title", "subtitle", "comment", "comment\137italic", "comment\137box",
    "start\137of_chorus", "end\137of_chorus", "start\137of_tab", "end\137of_tab", "define"
  };

  localparam logic [3:0] LONG_LEN [NUM_LABELS] = '{
    4'd8, 4'd5, 4'd8, 4'd7, 4'd14, 4'd11, 4'd15, 4'd13, 4'd12, 4'd10, 4'd6
  };

  localparam label_text_t SHORT_TEXT [NUM_LABELS] = '{
    "ns", "t", "st", "c", "ci", "cb", "soc", "eoc", "sot", "eot", '0
  };

  localparam logic [3:0] SHORT_LEN [NUM_LABELS] = '{
    4'd2, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd0
  };

  // Labels are right-aligned, so the first character sits highest.
  function automatic logic [7:0] label_byte(label_text_t txt, logic [3:0] len,
                                            logic [3:0] pos);
    logic [3:0] sh;
    sh = len - pos - 4'd1;
    return txt[{sh, 3'b000} +: 8];
  endfunction

endpackage

// ----- rtl/csp_front.sv -----
module csp_front #(
  parameter int unsigned NAME_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  csp_pkg::in_word_t  in_word_i,
  output logic               push_o,
  output csp_pkg::res_pair_t pair_o
);
  import csp_pkg::*;

  localparam int unsigned LenW = $clog2(NAME_MAX + 1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_TEXT    = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_NAME    = 3'd3;
  localparam logic [2:0] MODE_ARG     = 3'd4;

  logic [2:0]            mode_q, mode_d;
  logic                  line_q, line_d;
  logic [LenW-1:0]       len_q, len_d;
  logic                  too_long_q, too_long_d;
  logic [NUM_LABELS-1:0] scand_q, scand_d, lcand_q, lcand_d;
  logic [NUM_LABELS-1:0] skeep, lkeep;
  logic [3:0]            dir_id;
  logic                  name_clr, name_acc, start_tok;
  logic                  is_hash, is_lbrace, is_rbrace, is_colon, is_nl, eot;
  logic [7:0]            c;
  out_word_t             word [2];
  logic [1:0]            cnt;

  function automatic out_word_t mk(logic kind, logic [1:0] tt, logic [3:0] id,
                                   logic [7:0] ch);
    out_word_t w;
    w.rec_kind     = kind;
    w.token_type   = tt;
    w.directive_id = id;
    w.char_out     = ch;
    w.last_of_run  = 1'b0;
    return w;
  endfunction

  assign c         = in_word_i.in_char;
  assign eot       = in_word_i.end_of_text;
  assign is_hash   = (c == CH_HASH);
  assign is_lbrace = (c == CH_LBRACE);
  assign is_rbrace = (c == CH_RBRACE);
  assign is_colon  = (c == CH_COLON);
  assign is_nl     = (c == CH_NEWLINE);

  // Each label stays a candidate while every name byte so far matches it.
  always_comb begin
    for (int k = 0; k < NUM_LABELS; k++) begin
      skeep[k] = scand_q[k] && (len_q < LenW'(SHORT_LEN[k]))
                 && (label_byte(SHORT_TEXT[k], SHORT_LEN[k], len_q[3:0]) == c);
      lkeep[k] = lcand_q[k] && (len_q < LenW'(LONG_LEN[k]))
                 && (label_byte(LONG_TEXT[k], LONG_LEN[k], len_q[3:0]) == c);
    end
  end

  always_comb begin
    dir_id = ID_UNKNOWN;
    if (!too_long_q && len_q != '0) begin
      for (int k = NUM_LABELS - 1; k >= 0; k--) begin
        if ((scand_q[k] && SHORT_LEN[k] != 4'd0 && len_q == LenW'(SHORT_LEN[k]))
            || (lcand_q[k] && len_q == LenW'(LONG_LEN[k]))) begin
          dir_id = 4'(k + 1);
        end
      end
    end
  end

  always_comb begin
    mode_d     = mode_q;
    name_clr   = 1'b0;
    name_acc   = 1'b0;
    start_tok  = 1'b0;
    cnt        = 2'd0;
    word[0]    = mk(REC_CHAR, TT_TEXT, ID_UNKNOWN, 8'h00);
    word[1]    = mk(REC_CHAR, TT_TEXT, ID_UNKNOWN, 8'h00);
    unique case (mode_q) inside
      MODE_TEXT: begin
        if ((line_q && is_hash) || is_lbrace) begin
          word[cnt[0]] = mk(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00);
          cnt = cnt + 2'd1;
          start_tok = 1'b1;
        end else begin
          word[cnt[0]] = mk(REC_CHAR, TT_TEXT, ID_UNKNOWN, c);
          cnt = cnt + 2'd1;
          if (eot) begin
            word[cnt[0]] = mk(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00);
            cnt = cnt + 2'd1;
          end
        end
      end
      MODE_COMMENT: begin
        if (is_nl) begin
          word[cnt[0]] = mk(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00);
          cnt = cnt + 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          word[cnt[0]] = mk(REC_CHAR, TT_COMMENT, ID_UNKNOWN, c);
          cnt = cnt + 2'd1;
          if (eot) begin
            word[cnt[0]] = mk(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00);
            cnt = cnt + 2'd1;
          end
        end
      end
      MODE_NAME, MODE_ARG: begin
        if (is_rbrace) begin
          word[cnt[0]] = mk(REC_END, TT_DIRECTIVE, dir_id, 8'h00);
          cnt = cnt + 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          if (mode_q == MODE_ARG) begin
            word[cnt[0]] = mk(REC_CHAR, TT_DIRECTIVE, ID_UNKNOWN, c);
            cnt = cnt + 2'd1;
          end else if (is_colon) begin
            mode_d = MODE_ARG;
          end else begin
            name_acc = 1'b1;
          end
          if (eot) begin
            word[cnt[0]] = mk(REC_END, TT_DROPPED, ID_UNKNOWN, 8'h00);
            cnt = cnt + 2'd1;
          end
        end
      end
      default: begin
        start_tok = 1'b1;
      end
    endcase

    if (start_tok) begin
      if (line_q && is_hash) begin
        mode_d = MODE_COMMENT;
        if (eot) begin
          word[cnt[0]] = mk(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00);
          cnt = cnt + 2'd1;
        end
      end else if (is_lbrace) begin
        mode_d = MODE_NAME;
        name_clr = 1'b1;
        if (eot) begin
          word[cnt[0]] = mk(REC_END, TT_DROPPED, ID_UNKNOWN, 8'h00);
          cnt = cnt + 2'd1;
        end
      end else begin
        mode_d = MODE_TEXT;
        word[cnt[0]] = mk(REC_CHAR, TT_TEXT, ID_UNKNOWN, c);
        cnt = cnt + 2'd1;
        if (eot) begin
          word[cnt[0]] = mk(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00);
          cnt = cnt + 2'd1;
        end
      end
    end

    if (cnt == 2'd2) begin
      word[1].last_of_run = 1'b1;
    end else begin
      word[0].last_of_run = 1'b1;
    end
  end

  always_comb begin
    len_d      = len_q;
    too_long_d = too_long_q;
    scand_d    = scand_q;
    lcand_d    = lcand_q;
    line_d     = is_nl;
    if (name_clr) begin
      len_d      = '0;
      too_long_d = 1'b0;
      scand_d    = '1;
      lcand_d    = '1;
    end else if (name_acc) begin
      if (len_q < LenW'(NAME_MAX)) begin
        len_d   = len_q + 1'b1;
        scand_d = skeep;
        lcand_d = lkeep;
      end else begin
        too_long_d = 1'b1;
      end
    end
    if (eot) begin
      line_d     = 1'b1;
      len_d      = '0;
      too_long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      line_q     <= 1'b1;
      len_q      <= '0;
      too_long_q <= 1'b0;
      scand_q    <= '0;
      lcand_q    <= '0;
    end else if (fire_i) begin
      mode_q     <= eot ? MODE_IDLE : mode_d;
      line_q     <= line_d;
      len_q      <= len_d;
      too_long_q <= too_long_d;
      scand_q    <= scand_d;
      lcand_q    <= lcand_d;
    end
  end

  assign push_o        = fire_i && (cnt != 2'd0);
  assign pair_o.two    = (cnt == 2'd2);
  assign pair_o.first  = word[0];
  assign pair_o.second = word[1];

  a_eot_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && in_word_i.end_of_text |=> mode_q == MODE_IDLE && line_q)
    else $error("parser not idle at line start after end of text");

  a_last_marks_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (pair_o.two ? (!pair_o.first.last_of_run && pair_o.second.last_of_run)
                           : pair_o.first.last_of_run))
    else $error("last_of_run not on the final word of an item");

  a_id_only_on_directive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && pair_o.first.directive_id != ID_UNKNOWN
      |-> pair_o.first.rec_kind == REC_END && pair_o.first.token_type == TT_DIRECTIVE
        && !pair_o.two)
    else $error("directive id on a word that is not a directive end");

endmodule

// ----- rtl/csp_fifo.sv -----
module csp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csp_pkg::res_pair_t data_i,
  input  logic               pop_i,
  output csp_pkg::res_pair_t data_o,
  output logic               full_o,
  output logic               empty_o
);
  import csp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  res_pair_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/csp_back.sv -----
module csp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csp_pkg::res_pair_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csp_pkg::out_word_t out_word_o
);
  import csp_pkg::*;

  logic      valid_q, valid_d;
  logic      sel_q, sel_d;
  out_word_t word_q;
  logic      load;

  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && (sel_q || !head_i.two);

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !sel_q && head_i.two;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= sel_q ? head_i.second : head_i.first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ----- rtl/chord_sheet_token_parser.sv -----
// Chord sheet token parser. One song-text byte is taken per word on the input
// channel, and one result word leaves per cycle on the output channel while
// results are queued and the output is not stalled. The parser handles a byte
// in the cycle it is accepted and places its zero, one or two results into a
// FIFO_DEPTH-entry queue, so input is accepted every cycle while the queue has
// room; the output register then takes one result at a time, so a byte that
// yields two results (a content byte together with a token end, or two token
// ends) takes the output for each in turn. A byte's results go into the queue
// when the byte is accepted and then pass through the output register, which
// a stalled output holds. Directive names are matched against the label set
// one byte at a time as they arrive, so the closing brace record has its id.
module chord_sheet_token_parser #(
  parameter int unsigned NAME_MAX   = 16,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  csp_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output csp_pkg::out_word_t out_word_o
);
  import csp_pkg::*;

  logic      fire, push, pop, full, empty;
  res_pair_t pair, head;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && in_ready_o;

  csp_front #(
    .NAME_MAX (NAME_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_word_i (in_word_i),
    .push_o    (push),
    .pair_o    (pair)
  );

  csp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pair),
    .pop_i   (pop),
    .data_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  csp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- verif/csp_checker.sv -----
`timescale 1ns / 100ps

module csp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  csp_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  csp_pkg::out_word_t out_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import csp_pkg::*;

  localparam int NAME_MAX = 16;

  typedef enum logic [2:0] {
    PM_IDLE,
    PM_TEXT,
    PM_COMMENT,
    PM_NAME,
    PM_ARG
  } parse_mode_e;

  string long_lbl [11] = '{
    "new\137song", "title", "subtitle", "comment", "comment\137italic", "comment\137box",
    "start\137of_chorus", "end\137of_chorus", "start\137of_tab", "end\137of_tab", "define"
  };
  string short_lbl [11] = '{
    "ns", "t", "st", "c", "ci", "cb", "soc", "eoc", "sot", "eot", ""
  };

  parse_mode_e mode;
  logic        line_start;
  logic [7:0]  name_buf [NAME_MAX];
  int          name_len;
  logic        name_long;
  out_word_t   step_words [$];
  out_word_t   expected_words [$];
  out_word_t   want;
  int          fails = 0;

  function automatic out_word_t word_of(logic kind, logic [1:0] tt, logic [3:0] id,
                                        logic [7:0] ch);
    out_word_t w;
    w.rec_kind     = kind;
    w.token_type   = tt;
    w.directive_id = id;
    w.char_out     = ch;
    w.last_of_run  = 1'b0;
    return w;
  endfunction

  function automatic logic name_is(string s);
    if (s.len() != name_len) return 1'b0;
    for (int i = 0; i < name_len; i++) begin
      if (name_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [3:0] directive_of_name();
    if (name_long || name_len == 0) return ID_UNKNOWN;
    for (int k = 0; k < 11; k++) begin
      if (name_is(short_lbl[k]) || name_is(long_lbl[k])) return 4'(k + 1);
    end
    return ID_UNKNOWN;
  endfunction

  task automatic open_token(input logic [7:0] c, input logic eot);
    if (line_start && c == CH_HASH) begin
      mode = PM_COMMENT;
      if (eot) step_words.push_back(word_of(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00));
    end else if (c == CH_LBRACE) begin
      mode      = PM_NAME;
      name_len  = 0;
      name_long = 1'b0;
      if (eot) step_words.push_back(word_of(REC_END, TT_DROPPED, ID_UNKNOWN, 8'h00));
    end else begin
      mode = PM_TEXT;
      step_words.push_back(word_of(REC_CHAR, TT_TEXT, ID_UNKNOWN, c));
      if (eot) step_words.push_back(word_of(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00));
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic eot);
    out_word_t w;
    step_words.delete();
    case (mode)
      PM_TEXT: begin
        if ((line_start && c == CH_HASH) || c == CH_LBRACE) begin
          step_words.push_back(word_of(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00));
          open_token(c, eot);
        end else begin
          step_words.push_back(word_of(REC_CHAR, TT_TEXT, ID_UNKNOWN, c));
          if (eot) step_words.push_back(word_of(REC_END, TT_TEXT, ID_UNKNOWN, 8'h00));
        end
      end
      PM_COMMENT: begin
        if (c == CH_NEWLINE) begin
          step_words.push_back(word_of(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00));
          mode = PM_IDLE;
        end else begin
          step_words.push_back(word_of(REC_CHAR, TT_COMMENT, ID_UNKNOWN, c));
          if (eot) step_words.push_back(word_of(REC_END, TT_COMMENT, ID_UNKNOWN, 8'h00));
        end
      end
      PM_NAME, PM_ARG: begin
        if (c == CH_RBRACE) begin
          step_words.push_back(word_of(REC_END, TT_DIRECTIVE, directive_of_name(), 8'h00));
          mode = PM_IDLE;
        end else begin
          if (mode == PM_ARG) begin
            step_words.push_back(word_of(REC_CHAR, TT_DIRECTIVE, ID_UNKNOWN, c));
          end else if (c == CH_COLON) begin
            mode = PM_ARG;
          end else if (name_len < NAME_MAX) begin
            name_buf[name_len] = c;
            name_len++;
          end else begin
            name_long = 1'b1;
          end
          if (eot) step_words.push_back(word_of(REC_END, TT_DROPPED, ID_UNKNOWN, 8'h00));
        end
      end
      default: open_token(c, eot);
    endcase
    if (eot) begin
      mode       = PM_IDLE;
      line_start = 1'b1;
      name_len   = 0;
      name_long  = 1'b0;
    end else begin
      line_start = (c == CH_NEWLINE);
    end
    foreach (step_words[i]) begin
      w = step_words[i];
      w.last_of_run = (i == step_words.size() - 1);
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode       = PM_IDLE;
      line_start = 1'b1;
      name_len   = 0;
      name_long  = 1'b0;
      expected_words.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_tokens(in_word_i.in_char, in_word_i.end_of_text);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %h", $time, out_word_i);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_word_i) begin
            $display("%0t: word mismatch: expected kind %0d type %0d id %0d char %h last %0d",
                     $time, want.rec_kind, want.token_type, want.directive_id,
                     want.char_out, want.last_of_run);
            $display("%0t:                  actual kind %0d type %0d id %0d char %h last %0d",
                     $time, out_word_i.rec_kind, out_word_i.token_type,
                     out_word_i.directive_id, out_word_i.char_out, out_word_i.last_of_run);
            fails++;
          end
        end
      end
    end
    pending_o    <= expected_words.size();
    fail_count_o <= fails;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import csp_pkg::*;

  localparam int LIMIT       = 2000;
  localparam int TOTAL_BYTES = 25 + 1150;

  typedef logic [7:0] byte_q_t [$];

  localparam logic [8:0] OPENING [25] = '{
    {1'b1, CH_HASH},
    {1'b0, "x"}, {1'b0, 8'hFF}, {1'b0, CH_HASH}, {1'b0, CH_NEWLINE},
    {1'b0, CH_HASH}, {1'b0, "q"}, {1'b0, CH_NEWLINE},
    {1'b0, CH_LBRACE}, {1'b0, CH_COLON}, {1'b0, "a"}, {1'b0, CH_COLON}, {1'b0, CH_RBRACE},
    {1'b0, CH_LBRACE}, {1'b0, "t"}, {1'b0, CH_NEWLINE}, {1'b0, CH_RBRACE},
    {1'b0, CH_LBRACE}, {1'b0, "c"}, {1'b0, CH_RBRACE},
    {1'b0, CH_LBRACE}, {1'b1, "x"},
    {1'b1, "a"},
    {1'b0, 8'h00}, {1'b1, CH_LBRACE}
  };

  string labels [21] = '{
    "new\137song", "title", "subtitle", "comment", "comment\137italic", "comment\137box",
    "start\137of_chorus", "end\137of_chorus", "start\137of_tab", "end\137of_tab", "define",
    "ns", "t", "st", "c", "ci", "cb", "soc", "eoc", "sot", "eot"
  };

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  logic      calm      = 1'b0;
  int        fails;
  int        pending;
  int        sent      = 0;
  int        stuck     = 0;

  chord_sheet_token_parser uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  csp_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck <= 0;
      end else if (stuck + 1 >= LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eot);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid              <= 1'b1;
    in_word.in_char       <= c;
    in_word.end_of_text   <= eot;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  function automatic logic [7:0] song_char();
    int r;
    r = $urandom_range(99);
    if (r < 5) return CH_NEWLINE;
    if (r < 9) return CH_COLON;
    return 8'($urandom_range(32, 126));
  endfunction

  // Mostly well-formed comments and directives with random names and bodies;
  // the rest is plain text and raw noise.
  task automatic send_token();
    byte_q_t q;
    string   s;
    int      pick;
    int      form;
    int      at;
    pick = $urandom_range(99);
    if (pick < 40) begin
      q.push_back(CH_LBRACE);
      at   = q.size();
      s    = labels[$urandom_range(20)];
      form = $urandom_range(9);
      if (form == 6) begin
        // The name stays empty.
      end else if (form == 7) begin
        repeat ($urandom_range(15, 22)) q.push_back(8'($urandom_range(97, 122)));
      end else begin
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        if (form == 8) q[at + $urandom_range(s.len() - 1)] ^= 8'h20;
        if (form == 9) q.push_back("s");
      end
      if ($urandom_range(9) < 7) begin
        q.push_back(CH_COLON);
        repeat ($urandom_range(0, 6)) q.push_back(song_char());
      end
      if ($urandom_range(9) != 0) q.push_back(CH_RBRACE);
    end else if (pick < 65) begin
      q.push_back(CH_NEWLINE);
      q.push_back(CH_HASH);
      repeat ($urandom_range(0, 8)) q.push_back(8'($urandom_range(32, 126)));
      q.push_back(CH_NEWLINE);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 10)) q.push_back(song_char());
      if ($urandom_range(3) == 0) q.push_back(CH_HASH);
    end else begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
    end
    foreach (q[i]) send_byte(q[i], $urandom_range(99) < 2);
  endtask

  initial begin
    int cyc;
    cyc = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (cyc >= 400 && cyc < 600) begin
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 31);
      end
      cyc++;
      @(posedge clk_i);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (OPENING[i]) send_byte(OPENING[i][7:0], OPENING[i][8]);
    while (sent < TOTAL_BYTES) begin
      calm <= (sent >= 500 && sent < 700);
      send_token();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
